### rtl/vt4_pkg.sv
`default_nettype none
package vt4_pkg;

  // Number of configuration registers, two matrix cells each
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned NUM_LANES = 4;

  // Q16.16 component, exact product and four-term sum
  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] sum_t;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_POINT2 = 2'd0,
    KIND_POINT3 = 2'd1,
    KIND_DIR3   = 2'd2,
    KIND_VEC4   = 2'd3
  } kind_t;

  // Load strobes for the two lane pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
  } stage_en_t;

  localparam q16_t ONE_Q16 = 32'sh0001_0000;

  // Identity matrix after reset
  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage
`default_nettype wire

### rtl/vt4_lane.sv
`default_nettype none
// One output row: four exact products, then their sum
module vt4_lane (
  input  wire logic             clk,
  input  vt4_pkg::stage_en_t    en,
  input  vt4_pkg::q16_t         cells [4],
  input  vt4_pkg::q16_t         vec   [4],
  output vt4_pkg::sum_t         sum
);
  import vt4_pkg::*;

  prod_t prod_r [4];
  sum_t  sum_r;

  // Multiply each column cell by its vector component
  always_ff @(posedge clk) begin
    if (en.ld1) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c] <= prod_t'(cells[c]) * prod_t'(vec[c]);
      end
    end
  end

  // Add the four products at full precision
  always_ff @(posedge clk) begin
    if (en.ld2) begin
      sum_r <= sum_t'(prod_r[0]) + sum_t'(prod_r[1])
             + sum_t'(prod_r[2]) + sum_t'(prod_r[3]);
    end
  end

  assign sum = sum_r;

endmodule
`default_nettype wire

### rtl/vt4_merge.sv
`default_nettype none
// Floor, saturate and mask the lane sums; output register
module vt4_merge (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  vt4_pkg::kind_t        kind,
  input  vt4_pkg::sum_t         sums [4],
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [127:0]          out_tdata,
  output logic [0:0]            out_tuser
);
  import vt4_pkg::*;

  typedef logic signed [49:0] flo_t;

  localparam flo_t SAT_MAX = flo_t'(32'sh7FFF_FFFF);
  localparam flo_t SAT_MIN = flo_t'(32'sh8000_0000);

  flo_t           flo     [4];
  logic [3:0]     used;
  logic [3:0]     clip;
  q16_t           res     [4];
  logic           out_valid_r, out_valid_nxt;
  logic [127:0]   data_r;
  logic           sat_r;

  // Rows produced by each kind
  always_comb begin
    used[0] = 1'b1;
    used[1] = 1'b1;
    used[2] = (kind != KIND_POINT2);
    used[3] = (kind == KIND_VEC4);
  end

  // Drop 16 fraction bits (floor), then clip to 32 bits
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      flo[r]  = flo_t'(sums[r][65:16]);
      clip[r] = 1'b0;
      if (!used[r]) begin
        res[r] = '0;
      end else if (flo[r] > SAT_MAX) begin
        res[r]  = 32'sh7FFF_FFFF;
        clip[r] = 1'b1;
      end else if (flo[r] < SAT_MIN) begin
        res[r]  = 32'sh8000_0000;
        clip[r] = 1'b1;
      end else begin
        res[r] = q16_t'(flo[r][31:0]);
      end
    end
  end

  assign in_ready      = !out_valid_r || out_tready;
  assign out_valid_nxt = in_ready ? in_valid : out_valid_r;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= {res[3], res[2], res[1], res[0]};
      sat_r  <= |clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = sat_r;

endmodule
`default_nettype wire

### rtl/vertex_transform_4x4.sv
// vertex_transform_4x4: multiplies one vector per item by a column-major 4x4
// matrix of signed Q16.16 cells held in eight 64-bit configuration registers.
// Input channel (in_): tdata carries x, y, z, w (32 bits each, x lowest);
// tuser carries the kind: 2D point, 3D point, 3D direction or 4D vector.
// Output channel (out_): tdata carries the transformed x, y, z, w; tuser
// carries the saturation flag. Rows a kind does not produce read as zero.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at the clock
// edge; write only while no item is in flight.
// Pipeline: an accepted item loads the product, sum and output registers in
// turn; out_tvalid rises with the last. Four row lanes run in parallel, each
// with four 32x32 multipliers and a four-term adder stage, then a shared
// floor and saturation stage; one item per cycle while out_tready is high.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// matrix. When the receiver stalls, the result holds in the output register
// and items keep entering until every stage is full; in_tready then drops.
`default_nettype none
module vertex_transform_4x4 (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,   // in_x, in_y, in_z, in_w
  input  wire logic [1:0]    in_tuser,   // req_type
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [127:0]       out_tdata,  // out_x, out_y, out_z, out_w
  output logic [0:0]         out_tuser,  // saturated
  input  wire logic          cfg_we,
  input  wire logic [vt4_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [vt4_pkg::REG_W-1:0]     cfg_wdata
);
  import vt4_pkg::*;

  logic [REG_W-1:0] cfg_r [NUM_REGS];

  q16_t       vec       [4];
  q16_t       lane_cell [NUM_LANES][4];
  sum_t       lane_sum  [NUM_LANES];
  kind_t      kind_in;
  kind_t      kind1_r, kind2_r;
  logic       valid1_r, valid1_nxt;
  logic       valid2_r, valid2_nxt;
  logic       ready1, ready2, ready3;
  stage_en_t  en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Route cell c*4+r to lane r, column c
  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int c = 0; c < 4; c++) begin
        lane_cell[r][c] = q16_t'(cfg_r[(c*4 + r) / 2][((c*4 + r) % 2)*32 +: 32]);
      end
    end
  end

  // Form the vector from the kind
  assign kind_in = kind_t'(in_tuser);

  always_comb begin
    vec[0] = q16_t'(in_tdata[31:0]);
    vec[1] = q16_t'(in_tdata[63:32]);
    vec[2] = (kind_in == KIND_POINT2) ? '0 : q16_t'(in_tdata[95:64]);
    case (kind_in)
      KIND_VEC4: vec[3] = q16_t'(in_tdata[127:96]);
      KIND_DIR3: vec[3] = '0;
      default:   vec[3] = ONE_Q16;
    endcase
  end

  // Pipeline control: a stage loads when it is empty or draining
  assign ready2     = !valid2_r || ready3;
  assign ready1     = !valid1_r || ready2;
  assign in_tready  = ready1;
  assign en.ld1     = ready1;
  assign en.ld2     = ready2;
  assign valid1_nxt = ready1 ? in_tvalid : valid1_r;
  assign valid2_nxt = ready2 ? valid1_r : valid2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= valid1_nxt;
      valid2_r <= valid2_nxt;
    end
  end

  // Carry the kind alongside the lane stages
  always_ff @(posedge clk) begin
    if (ready1) begin
      kind1_r <= kind_in;
    end
    if (ready2) begin
      kind2_r <= kind1_r;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vt4_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cells (lane_cell[g]),
      .vec   (vec),
      .sum   (lane_sum[g])
    );
  end

  vt4_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (valid2_r),
    .in_ready   (ready3),
    .kind       (kind2_r),
    .sums       (lane_sum),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### rtl/vt4_checker.sv
`default_nettype none
module vt4_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_tvalid,
  input wire logic          in_tready,
  input wire logic          out_tvalid,
  input wire logic          out_tready,
  input wire logic [127:0]  out_tdata,
  input wire logic [0:0]    out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // A taking receiver never stalls the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is taken");

  // An accepted item reaches the output with a free receiver
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("item did not reach output in three cycles");

  // Saturation shows a clipped component
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[31:0]   == 32'h7FFF_FFFF) || (out_tdata[31:0]   == 32'h8000_0000) ||
      (out_tdata[63:32]  == 32'h7FFF_FFFF) || (out_tdata[63:32]  == 32'h8000_0000) ||
      (out_tdata[95:64]  == 32'h7FFF_FFFF) || (out_tdata[95:64]  == 32'h8000_0000) ||
      (out_tdata[127:96] == 32'h7FFF_FFFF) || (out_tdata[127:96] == 32'h8000_0000))
    else $error("saturated flag without a clipped component");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
